// ===== rtl/rne_pkg.sv =====
// Package: types, constants and letter tables of the Roman numeral encoder.
`default_nettype none
package rne_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 8;
    localparam int POS_W   = 2;
    localparam int DIG_W   = 4;
    localparam int CNT_W   = 2;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;
    localparam logic [POS_W-1:0]   POS_THOUSANDS = 2'd3;

    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EMIT,
        S_BAD
    } t_state;

    typedef struct packed {
        logic load_in;
        logic load_digit;
        logic skip_pos;
        logic next_letter;
        logic next_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_bad;
        logic digit_zero;
        logic digit_end;
        logic last;
    } t_dp_sts;

    // decimal digit of the remainder at a position; remainder is below 10^(pos+1)
    function automatic logic [DIG_W-1:0] digit_of(input logic [POS_W-1:0] pos,
                                                  input logic [VALUE_W-1:0] rem);
        logic [15:0] p_hund;
        logic [13:0] p_tens;
        logic [DIG_W-1:0] d;
        p_hund = 16'(rem[9:0]) * 16'd41;
        p_tens = 14'(rem[6:0]) * 14'd103;
        case (pos)
            2'd3: begin
                if (rem >= 12'd3000) d = 4'd3;
                else if (rem >= 12'd2000) d = 4'd2;
                else if (rem >= 12'd1000) d = 4'd1;
                else d = 4'd0;
            end
            2'd2:    d = p_hund[15:12];
            2'd1:    d = p_tens[13:10];
            default: d = rem[3:0];
        endcase
        return d;
    endfunction

    function automatic logic [VALUE_W-1:0] weight_of(input logic [POS_W-1:0] pos,
                                                     input logic [DIG_W-1:0] d);
        logic [VALUE_W-1:0] w;
        case (pos)
            2'd3:    w = VALUE_W'(d) * 12'd1000;
            2'd2:    w = VALUE_W'(d) * 12'd100;
            2'd1:    w = VALUE_W'(d) * 12'd10;
            default: w = VALUE_W'(d);
        endcase
        return w;
    endfunction

    // number of letters for one digit, minus one
    function automatic logic [CNT_W-1:0] len_m1(input logic [DIG_W-1:0] d);
        logic [CNT_W-1:0] n;
        case (d)
            4'd2, 4'd4, 4'd6, 4'd9: n = 2'd1;
            4'd3, 4'd7:             n = 2'd2;
            4'd8:                   n = 2'd3;
            default:                n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [SYM_W-1:0] letter_of(input logic [POS_W-1:0] pos,
                                                   input logic [DIG_W-1:0] d,
                                                   input logic [CNT_W-1:0] k);
        logic [SYM_W-1:0] u;
        logic [SYM_W-1:0] f;
        logic [SYM_W-1:0] t;
        logic [SYM_W-1:0] s;
        case (pos)
            2'd3: begin
                u = SYM_M; f = SYM_M; t = SYM_M;
            end
            2'd2: begin
                u = SYM_C; f = SYM_D; t = SYM_M;
            end
            2'd1: begin
                u = SYM_X; f = SYM_L; t = SYM_C;
            end
            default: begin
                u = SYM_I; f = SYM_V; t = SYM_X;
            end
        endcase
        case (d)
            4'd4:                   s = (k == 2'd0) ? u : f;
            4'd5, 4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? f : u;
            4'd9:                   s = (k == 2'd0) ? u : t;
            default:                s = u;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rne_in_if.sv =====
// Interface: input channel carrying the binary value.
`default_nettype none
interface rne_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/rne_out_if.sv =====
// Interface: output channel carrying one numeral letter per beat.
`default_nettype none
interface rne_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;
    logic       invalid;

    modport source (output valid, output symbol, output last, output invalid, input ready);
    modport sink   (input valid, input symbol, input last, input invalid, output ready);
endinterface
`default_nettype wire

// ===== rtl/rne_ctrl.sv =====
// Controller: state machine sequencing load, digit extraction and letter beats.
`default_nettype none
module rne_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire rne_pkg::t_dp_sts i_sts,
    output rne_pkg::t_dp_cmd     o_cmd
);
    import rne_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.in_bad ? S_BAD : S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.digit_zero) begin
                    o_cmd.skip_pos = 1'b1;
                end else begin
                    o_cmd.load_digit = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else if (i_sts.digit_end) begin
                        o_cmd.next_digit = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.next_letter = 1'b1;
                    end
                end
            end
            S_BAD: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/rne_dpath.sv =====
// Datapath: remainder, digit position, digit and letter counter, letter lookup.
`default_nettype none
module rne_dpath (
    input  wire logic                          i_clk,
    input  wire logic [rne_pkg::VALUE_W-1:0]   i_value,
    input  wire rne_pkg::t_dp_cmd              i_cmd,
    output rne_pkg::t_dp_sts                   o_sts,
    output logic [rne_pkg::SYM_W-1:0]          o_symbol,
    output logic                               o_last,
    output logic                               o_invalid
);
    import rne_pkg::*;

    logic [VALUE_W-1:0] r_rem;
    logic [POS_W-1:0]   r_pos;
    logic [DIG_W-1:0]   r_digit;
    logic [CNT_W-1:0]   r_k;
    logic               r_bad;

    logic [DIG_W-1:0]   digit_now;
    logic [VALUE_W-1:0] weight;
    logic               digit_end;
    logic               rest_zero;

    assign digit_now = digit_of(r_pos, r_rem);
    assign weight    = weight_of(r_pos, r_digit);
    assign digit_end = (r_k == len_m1(r_digit));
    assign rest_zero = (r_rem == weight);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rem <= i_value;
            r_pos <= POS_THOUSANDS;
            r_bad <= (i_value == '0) || (i_value >= VALUE_LIMIT);
        end
        if (i_cmd.skip_pos) begin
            r_pos <= r_pos - 1'b1;
        end
        if (i_cmd.load_digit) begin
            r_digit <= digit_now;
            r_k     <= '0;
        end
        if (i_cmd.next_letter) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.next_digit) begin
            r_rem <= r_rem - weight;
            r_pos <= r_pos - 1'b1;
        end
    end

    always_comb begin
        o_sts.in_bad     = (i_value == '0) || (i_value >= VALUE_LIMIT);
        o_sts.digit_zero = (digit_now == '0);
        o_sts.digit_end  = digit_end;
        o_sts.last       = digit_end && rest_zero;
    end

    assign o_symbol  = r_bad ? SYM_NONE : letter_of(r_pos, r_digit, r_k);
    assign o_last    = r_bad | (digit_end & rest_zero);
    assign o_invalid = r_bad;
endmodule
`default_nettype wire

// ===== rtl/roman_numeral_encoder_top.sv =====
// Top level: Roman numeral encoder, binary value in, one ASCII letter per beat out.
//
//   channel  dir  payload                          beat
//   i_in     in   value[11:0]                      one per conversion
//   o_out    out  symbol[7:0], last, invalid       one per letter, last on final
//
// A valid value is accepted, then each decimal position from the thousands down to the
// lowest nonzero digit is loaded or skipped, and each letter goes out as one beat.
// Value 0 or 4000 and up is accepted, then gives one invalid beat.
// Reset returns the controller to idle; the output beat holds while o_out.ready is low.
// A new value is taken only once the last beat of the previous one has gone.
`default_nettype none
module roman_numeral_encoder_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    rne_in_if.sink   i_in,
    rne_out_if.source o_out
);
    import rne_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rne_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rne_dpath u_dpath (
        .i_clk     (i_clk),
        .i_value   (i_in.value),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_symbol  (o_out.symbol),
        .o_last    (o_out.last),
        .o_invalid (o_out.invalid)
    );
endmodule
`default_nettype wire

// ===== dv/tb_roman_numeral_encoder_top.sv =====
// Testbench: feeds values to the Roman numeral encoder and checks every letter beat it returns.
`timescale 1ns / 100ps
module tb_roman_numeral_encoder_top;
    import rne_pkg::*;

    localparam int RANDOM_VALUES = 75;
    localparam int IDLE_PCT      = 28;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 25;
    localparam int MAX_LETTERS   = 15;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             invalid;
    } t_letter_beat;

    // numeral is right-justified ASCII; a typed row with no letters means one invalid beat
    typedef struct packed {
        logic [VALUE_W-1:0]         value;
        logic                       typed;
        logic [8*MAX_LETTERS-1:0]   numeral;
    } t_value_row;

    logic i_clk;
    logic i_rst_n;

    rne_in_if  in_ch ();
    rne_out_if out_ch ();

    roman_numeral_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_value_row directed_rows [DIRECTED_ROWS] = '{
        '{12'd0,    1'b1, ""},
        '{12'd1,    1'b1, "I"},
        '{12'd3,    1'b0, ""},
        '{12'd4,    1'b0, ""},
        '{12'd5,    1'b0, ""},
        '{12'd6,    1'b0, ""},
        '{12'd7,    1'b0, ""},
        '{12'd9,    1'b0, ""},
        '{12'd14,   1'b0, ""},
        '{12'd40,   1'b0, ""},
        '{12'd49,   1'b0, ""},
        '{12'd90,   1'b0, ""},
        '{12'd400,  1'b0, ""},
        '{12'd444,  1'b0, ""},
        '{12'd900,  1'b0, ""},
        '{12'd999,  1'b0, ""},
        '{12'd1000, 1'b1, "M"},
        '{12'd1994, 1'b0, ""},
        '{12'd2048, 1'b0, ""},
        '{12'd2762, 1'b0, ""},
        '{12'd3000, 1'b1, "MMM"},
        '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
        '{12'd3999, 1'b1, "MMMCMXCIX"},
        '{12'd4000, 1'b1, ""},
        '{12'd4095, 1'b1, ""}
    };

    t_letter_beat             pending_letters [$];
    t_letter_beat             want;
    logic                     in_typed;
    logic [8*MAX_LETTERS-1:0] in_numeral;
    bit                       steady;
    bit                       took_beat;
    int                       stall_cycles;
    int                       errors;
    int                       values_taken;
    int                       letters_seen;
    int                       invalid_seen;
    int                       longest_word;
    int                       word_len;

    function automatic void queue_beat(input logic [SYM_W-1:0] sym, input logic fin,
                                       input logic bad);
        t_letter_beat b;
        b = '{sym, fin, bad};
        pending_letters = {pending_letters, b};
    endfunction

    function automatic void encode_numeral(input logic [VALUE_W-1:0] v);
        logic [SYM_W-1:0] unit_sym [3];
        logic [SYM_W-1:0] five_sym [3];
        logic [SYM_W-1:0] ten_sym  [3];
        int unsigned      scale    [3];
        logic [SYM_W-1:0] word [$];
        int unsigned      d;
        unit_sym = '{SYM_I, SYM_X, SYM_C};
        five_sym = '{SYM_V, SYM_L, SYM_D};
        ten_sym  = '{SYM_X, SYM_C, SYM_M};
        scale    = '{1, 10, 100};
        if (v == '0 || v >= VALUE_LIMIT) begin
            queue_beat(SYM_NONE, 1'b1, 1'b1);
            return;
        end
        for (int k = 0; k < int'(v) / 1000; k++) word = {word, SYM_M};
        for (int pos = 2; pos >= 0; pos--) begin
            d = (int'(v) / scale[pos]) % 10;
            if (d == 4) begin
                word = {word, unit_sym[pos]};
                word = {word, five_sym[pos]};
            end else if (d == 9) begin
                word = {word, unit_sym[pos]};
                word = {word, ten_sym[pos]};
            end else begin
                if (d >= 5) word = {word, five_sym[pos]};
                for (int k = 0; k < d % 5; k++) word = {word, unit_sym[pos]};
            end
        end
        foreach (word[i]) queue_beat(word[i], i == word.size() - 1, 1'b0);
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v, input logic typed,
                              input logic [8*MAX_LETTERS-1:0] numeral);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = v;
        in_typed    = typed;
        in_numeral  = numeral;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_letters;
        in_ch.valid = 1'b0;
        while (pending_letters.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took_beat = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                took_beat = 1'b1;
                values_taken++;
                if (!in_typed) begin
                    encode_numeral(in_ch.value);
                end else if (in_numeral == '0) begin
                    queue_beat(SYM_NONE, 1'b1, 1'b1);
                end else begin
                    for (int i = MAX_LETTERS - 1; i >= 0; i--) begin
                        if (in_numeral[8*i +: 8] != 8'h00)
                            queue_beat(in_numeral[8*i +: 8], i == 0, 1'b0);
                    end
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                took_beat = 1'b1;
                if (out_ch.invalid) invalid_seen++;
                else letters_seen++;
                word_len = out_ch.invalid ? 0 : word_len + 1;
                if (word_len > longest_word) longest_word = word_len;
                if (out_ch.last) word_len = 0;
                if (pending_letters.size() == 0) begin
                    $display("%0t: unexpected beat, actual symbol=%h last=%b invalid=%b",
                             $time, out_ch.symbol, out_ch.last, out_ch.invalid);
                    errors++;
                end else begin
                    want = pending_letters.pop_front();
                    if (out_ch.symbol !== want.symbol) begin
                        $display("%0t: symbol mismatch, expected %h, actual %h",
                                 $time, want.symbol, out_ch.symbol);
                        errors++;
                    end
                    if (out_ch.last !== want.last) begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, out_ch.last);
                        errors++;
                    end
                    if (out_ch.invalid !== want.invalid) begin
                        $display("%0t: invalid mismatch, expected %b, actual %b",
                                 $time, want.invalid, out_ch.invalid);
                        errors++;
                    end
                end
            end
            stall_cycles = took_beat ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d letters outstanding",
                         $time, stall_cycles, pending_letters.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [VALUE_W-1:0] v;
        int unsigned        pick;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        steady        = 1'b0;
        in_typed      = 1'b0;
        in_numeral    = '0;
        stall_cycles  = 0;
        errors        = 0;
        values_taken  = 0;
        letters_seen  = 0;
        invalid_seen  = 0;
        longest_word  = 0;
        word_len      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].numeral);
        wait_for_letters();

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            steady = (n >= 30 && n < 60);
            if (n == 70) wait_for_letters();
            pick = $urandom_range(99);
            if (pick < 8) v = 12'($urandom_range(4095, 4000));
            else if (pick < 11) v = '0;
            else v = 12'($urandom_range(3999, 1));
            send_value(v, 1'b0, '0);
        end
        steady = 1'b0;
        wait_for_letters();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Converted %0d values: %0d letters and %0d out-of-range beats checked.",
                 values_taken, letters_seen, invalid_seen);
        $display("Longest numeral seen: %0d letters, with random stalls on both channels.",
                 longest_word);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== roman_numeral_encoder_top.f =====
rtl/rne_pkg.sv
rtl/rne_in_if.sv
rtl/rne_out_if.sv
rtl/rne_ctrl.sv
rtl/rne_dpath.sv
rtl/roman_numeral_encoder_top.sv
dv/tb_roman_numeral_encoder_top.sv
